@@ rtl/msc_pkg.sv @@
// Shared types, constants and image ROMs for the masked sprite line compositor.
package msc_pkg;

  localparam int NUM_SPRITES = 5;
  localparam int SPRITE_SIZE = 32;
  localparam int LINE_WIDTH  = 128;

  // Fixed storage geometry: ROM rows are 32 columns, the line buffer is 128 columns.
  localparam int SPRITE_BITS = 32;
  localparam int LINE_BITS   = 128;
  localparam int ROM_IMAGES  = 4;
  localparam int ROM_DEPTH   = ROM_IMAGES * SPRITE_BITS;
  localparam int PLACE_W     = LINE_BITS + 2 * SPRITE_BITS;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // ROM code for an image that draws nothing.
  localparam logic [2:0] ROM_NONE = 3'd4;

  // Columns used of each ROM row (bit 31 is column 0).
  localparam logic [SPRITE_BITS-1:0] COL_MASK = ~({SPRITE_BITS{1'b1}} >> SPRITE_SIZE);
  // Buffer bits that lie on screen (bit 127 is column 0).
  localparam logic [LINE_BITS-1:0] LINE_MASK = ~({LINE_BITS{1'b1}} >> LINE_WIDTH);

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [2:0]        image;
  } sprite_t;

  localparam sprite_t SPRITE_RESET = '{x: 9'h000, y: 9'h1E0, image: 3'd0};

  typedef struct packed {
    logic       vld;
    logic [6:0] line;
    sprite_t    entry;
  } draw_req_t;

  typedef struct packed {
    logic                 vld;
    logic [LINE_BITS-1:0] clr;
    logic [LINE_BITS-1:0] set;
  } draw_res_t;

  localparam logic [31:0] MASK_ROM [ROM_DEPTH] = '{
    // pose 0
    32'h00000000, 32'h00100000, 32'h00200000, 32'h00880000,
    32'h00100000, 32'h0043F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F8F0, 32'h07C7C700, 32'h0F1F082B, 32'h1E7C1100,
    32'h04F02056, 32'h61E42200, 32'h784840A8, 32'h4E104400,
    32'h539081F8, 32'h5CA09058, 32'h7CA10790, 32'h74A12138,
    32'h7FB50E30, 32'h77B09078, 32'h7FB460F0, 32'h77BB03E0,
    32'h7FBC0FC0, 32'h77BFFF00, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    // pose 1
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h0043F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F800, 32'h07C7C1E0, 32'h0F1F0610, 32'h1E7C0000,
    32'h04F007F0, 32'h61E41808, 32'h78482080, 32'h4E10402B,
    32'h53908100, 32'h5CA08058, 32'h7CA10200, 32'h74A128B8,
    32'h7FB50FF0, 32'h77B09078, 32'h7FB460F0, 32'h77BB03E0,
    32'h7FBC0FC0, 32'h77BFFF00, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    // pose 2
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h0003F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F800, 32'h07C7C1E0, 32'h0F1F0610, 32'h1E7C0000,
    32'h04F00000, 32'h61E40008, 32'h78480010, 32'h4E100018,
    32'h53906070, 32'h5CA09FC8, 32'h7CA10492, 32'h74A10924,
    32'h7FB50248, 32'h77B08010, 32'h7FB44100, 32'h77BB2040,
    32'h7FBC1000, 32'h77BFF800, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    // toast
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0003C000,
    32'h000C3000, 32'h00300C00, 32'h00C22300, 32'h070080C0,
    32'h08255030, 32'h100BA808, 32'h2137F504, 32'h304AE80C,
    32'h3C155234, 32'h2B0080EC, 32'h35C22354, 32'h1AB00EAC,
    32'h0D5C1558, 32'h03ABEAE0, 32'h00D55580, 32'h003AAE00,
    32'h000D5800, 32'h0003E000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  localparam logic [31:0] BITS_ROM [ROM_DEPTH] = '{
    // pose 0
    32'h00300000, 32'h00E80000, 32'h01D80000, 32'h0374F000,
    32'h07EFFE00, 32'h07BC0780, 32'h0FE07FE0, 32'h0F83C070,
    32'h1E0E0708, 32'h183838FF, 32'h30E0F7D4, 32'h6183EEFF,
    32'h7B0FDFA8, 32'h9E1BDDFE, 32'h87B7BF50, 32'hB1EFBBF8,
    32'hAC6F7E00, 32'hA35F6FA0, 32'h835EF868, 32'h8B5EDEC0,
    32'h804AF1C8, 32'h884F6F80, 32'h804B9F08, 32'h8844FC10,
    32'h8043F020, 32'h884000C0, 32'h80400300, 32'h40400C00,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    // pose 1
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0030F000,
    32'h00F7FE00, 32'h01BC0780, 32'h03E07FE0, 32'h0783C070,
    32'h0E0E07F8, 32'h18383E18, 32'h30E0F9E8, 32'h6183FFF8,
    32'h7B0FF808, 32'h9E1BE7F0, 32'h87B7DF7F, 32'hB1EFBFD4,
    32'hAC6F7EFF, 32'hA35F7FA6, 32'h835EFDF8, 32'h8B5ED740,
    32'h804AF008, 32'h884F6F80, 32'h804B9F08, 32'h8844FC10,
    32'h8043F020, 32'h884000C0, 32'h80400300, 32'h40400C00,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    // pose 2
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0000F000,
    32'h0007FE00, 32'h003C0780, 32'h00E07FE0, 32'h0383C070,
    32'h0E0E07F8, 32'h18383E18, 32'h30E0F9E8, 32'h6183FFF8,
    32'h7B0FFFF8, 32'h9E1BFFF0, 32'h87B7FFE8, 32'hB1EFFFE0,
    32'hAC6F9F88, 32'hA35F6036, 32'h835EFB6D, 32'h8B5EF6DB,
    32'h804AFDB6, 32'h884F7FEE, 32'h804BBEFC, 32'h8844DFBC,
    32'h8043EFF8, 32'h884007F0, 32'h804003E0, 32'h40400CC0,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    // toast
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h0003C000, 32'h000FF000, 32'h003DDC00, 32'h00FF7F00,
    32'h07DAAFC0, 32'h0FF457F0, 32'h1EC80AF8, 32'h0FB517F0,
    32'h03EAADC8, 32'h14FF7F10, 32'h0A3DDCA8, 32'h054FF150,
    32'h02A3EAA0, 32'h00541500, 32'h002AAA00, 32'h00055000,
    32'h0002A000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  // Image number to ROM image; pose 1 serves twice, codes above the toast draw nothing.
  function automatic logic [2:0] image_to_rom(input logic [2:0] image);
    logic [2:0] rom;
    case (image)
      3'd0:    rom = 3'd0;
      3'd1:    rom = 3'd1;
      3'd2:    rom = 3'd2;
      3'd3:    rom = 3'd1;
      3'd4:    rom = 3'd3;
      default: rom = ROM_NONE;
    endcase
    return rom;
  endfunction

endpackage

@@ rtl/msc_if.sv @@
// Valid/ready channel interfaces for sprite commands and rendered lines.
interface msc_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [2:0]        sprite_slot;
  logic signed [8:0] sprite_x;
  logic signed [8:0] sprite_y;
  logic [2:0]        sprite_image;
  logic [6:0]        line_y;

  modport source (
    output valid, action, sprite_slot, sprite_x, sprite_y, sprite_image, line_y,
    input  ready
  );
  modport sink (
    input  valid, action, sprite_slot, sprite_x, sprite_y, sprite_image, line_y,
    output ready
  );
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  line_index;
  logic [63:0] pixels_left;
  logic [63:0] pixels_right;

  modport source (
    output valid, line_index, pixels_left, pixels_right,
    input  ready
  );
  modport sink (
    input  valid, line_index, pixels_left, pixels_right,
    output ready
  );
endinterface

@@ rtl/masked_sprite_line_compositor.sv @@
// Masked sprite line compositor: sprite table in RAM, renders one 128-pixel scanline per beat.
// A write beat loads one sprite slot and gives no result. A render beat reads the sprite
// table memory one slot per cycle; each entry goes through the registered read port and
// one registered ROM fetch and placement stage, then a drain check and the output load
// finish the line, the load waiting while the output register holds an untaken line.
// Input is taken only while no render is in progress; a finished line waits in the output
// register, so the next beat may be accepted before it is taken. Slots are drawn in order,
// higher slots on top. The table comes out of reset with every sprite above the screen.
module masked_sprite_line_compositor #(
  parameter int NUM_SPRITES = msc_pkg::NUM_SPRITES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msc_in_if.sink    in_i,
  msc_out_if.source out_o
);

  localparam int AW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [AW-1:0]                 cnt_q, cnt_d;
  logic [6:0]                    line_q, line_d;
  logic [msc_pkg::LINE_BITS-1:0] buf_q, buf_d;

  msc_pkg::sprite_t              mem_q [NUM_SPRITES];
  logic [NUM_SPRITES-1:0]        ent_vld_q;
  logic                          mem_we;
  logic [AW-1:0]                 wr_addr;
  msc_pkg::sprite_t              wr_data;
  msc_pkg::sprite_t              rd_data_q;
  logic                          rd_ent_vld_q;
  logic                          rd_en;
  logic                          rd_vld_q;

  logic                          in_acc, out_acc, out_load;
  logic                          out_vld_q;
  logic [6:0]                    out_line_q;
  logic [msc_pkg::LINE_BITS-1:0] out_pix_q;

  msc_pkg::draw_req_t            draw_req;
  msc_pkg::draw_res_t            draw_res;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_vld_q && out_o.ready;

  assign mem_we  = in_acc && (in_i.action == msc_pkg::ACT_WRITE)
                   && (32'(in_i.sprite_slot) < NUM_SPRITES);
  assign wr_addr = AW'(in_i.sprite_slot);
  assign wr_data = '{x: in_i.sprite_x, y: in_i.sprite_y, image: in_i.sprite_image};
  assign rd_en   = (state_q == S_READ);

  // Sprite table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      rd_ent_vld_q <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      rd_ent_vld_q <= ent_vld_q[cnt_q];
      rd_vld_q     <= rd_en;
    end
  end

  // Never-written slots read as the reset entry
  always_comb begin
    draw_req.vld   = rd_vld_q;
    draw_req.line  = line_q;
    draw_req.entry = rd_ent_vld_q ? rd_data_q : msc_pkg::SPRITE_RESET;
  end

  msc_draw u_draw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (draw_req),
    .res_o  (draw_res)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    line_d   = line_q;
    buf_d    = buf_q;
    out_load = 1'b0;
    if (draw_res.vld) begin
      buf_d = (buf_q & ~draw_res.clr) | draw_res.set;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.action == msc_pkg::ACT_RENDER)) begin
          state_d = S_READ;
          cnt_d   = '0;
          line_d  = in_i.line_y;
          buf_d   = '0;
        end
      end
      S_READ: begin
        if (cnt_q == AW'(NUM_SPRITES - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !draw_res.vld) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    buf_q  <= buf_d;
    if (out_load) begin
      out_line_q <= line_q;
      out_pix_q  <= buf_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.line_index   = out_line_q;
  assign out_o.pixels_left  = out_pix_q[msc_pkg::LINE_BITS-1:64];
  assign out_o.pixels_right = out_pix_q[63:0];

`ifndef SYNTHESIS
  // A result appears only after a completed render
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("output beat raised without a finished render");

  // A render beat starts a table sweep from slot zero on a clear line
  a_render_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == msc_pkg::ACT_RENDER))
      |=> (state_q == S_READ) && (cnt_q == '0) && (buf_q == '0))
    else $error("render did not start a clean sweep");

  // The draw pipeline is empty whenever input is open
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rd_vld_q && !draw_res.vld))
    else $error("draw pipeline busy while idle");
`endif

endmodule

@@ rtl/msc_draw.sv @@
// Draw stage: row decode, ROM fetch and placement of one sprite row on the line.
module msc_draw (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msc_pkg::draw_req_t req_i,
  output msc_pkg::draw_res_t res_o
);

  logic signed [9:0]                row_s;
  logic [2:0]                       rom_s;
  logic                             hit_s;
  logic [msc_pkg::SPRITE_BITS-1:0]  mask_row_d, bits_row_d;
  logic [7:0]                       shift_d;
  logic                             vld_q, hit_q;
  logic [msc_pkg::SPRITE_BITS-1:0]  mask_row_q, bits_row_q;
  logic [7:0]                       shift_q;
  logic [msc_pkg::PLACE_W-1:0]      mask_wide, bits_wide;

  always_comb begin
    row_s = $signed({3'b000, req_i.line}) - $signed({req_i.entry.y[8], req_i.entry.y});
    rom_s = msc_pkg::image_to_rom(req_i.entry.image);
    // Row inside the sprite, image drawable, and left column between -31 and 127 so some column is on screen
    hit_s = !row_s[9] && (row_s < msc_pkg::SPRITE_SIZE) && (rom_s != msc_pkg::ROM_NONE)
            && (req_i.entry.x > -9'sd32) && (req_i.entry.x < 9'sd128);
    mask_row_d = msc_pkg::MASK_ROM[{rom_s[1:0], row_s[4:0]}] & msc_pkg::COL_MASK;
    bits_row_d = msc_pkg::BITS_ROM[{rom_s[1:0], row_s[4:0]}] & msc_pkg::COL_MASK;
    shift_d    = 8'(req_i.entry.x + 9'sd32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
      hit_q <= req_i.vld && hit_s;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_row_q <= mask_row_d;
    bits_row_q <= bits_row_d;
    shift_q    <= shift_d;
  end

  // Column c of the row lands at bit (LINE_BITS + SPRITE_BITS - 1 - x - c) of the wide word
  always_comb begin
    mask_wide = {mask_row_q, {(msc_pkg::PLACE_W - msc_pkg::SPRITE_BITS){1'b0}}} >> shift_q;
    bits_wide = {bits_row_q, {(msc_pkg::PLACE_W - msc_pkg::SPRITE_BITS){1'b0}}} >> shift_q;
    res_o.vld = vld_q;
    res_o.clr = '0;
    res_o.set = '0;
    if (hit_q) begin
      res_o.clr = mask_wide[msc_pkg::LINE_BITS+msc_pkg::SPRITE_BITS-1:msc_pkg::SPRITE_BITS]
                  & msc_pkg::LINE_MASK;
      res_o.set = bits_wide[msc_pkg::LINE_BITS+msc_pkg::SPRITE_BITS-1:msc_pkg::SPRITE_BITS]
                  & msc_pkg::LINE_MASK;
    end
  end

endmodule

@@ test/tb_masked_sprite_line_compositor.sv @@
// Self-checking testbench for the masked sprite line compositor: random sprite writes and renders.
`timescale 1ns / 100ps

module tb_masked_sprite_line_compositor;

  localparam int NUM_SLOTS       = msc_pkg::NUM_SPRITES;
  localparam int SPR_EDGE        = msc_pkg::SPRITE_SIZE;
  localparam int SCREEN_W        = msc_pkg::LINE_WIDTH;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  // Image shapes, 32 rows per image, bit 31 is the leftmost column.
  localparam logic [31:0] SHAPE_MASK [128] = '{
    32'h00000000, 32'h00100000, 32'h00200000, 32'h00880000,
    32'h00100000, 32'h0043F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F8F0, 32'h07C7C700, 32'h0F1F082B, 32'h1E7C1100,
    32'h04F02056, 32'h61E42200, 32'h784840A8, 32'h4E104400,
    32'h539081F8, 32'h5CA09058, 32'h7CA10790, 32'h74A12138,
    32'h7FB50E30, 32'h77B09078, 32'h7FB460F0, 32'h77BB03E0,
    32'h7FBC0FC0, 32'h77BFFF00, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h0043F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F800, 32'h07C7C1E0, 32'h0F1F0610, 32'h1E7C0000,
    32'h04F007F0, 32'h61E41808, 32'h78482080, 32'h4E10402B,
    32'h53908100, 32'h5CA08058, 32'h7CA10200, 32'h74A128B8,
    32'h7FB50FF0, 32'h77B09078, 32'h7FB460F0, 32'h77BB03E0,
    32'h7FBC0FC0, 32'h77BFFF00, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h0003F800, 32'h001F8000, 32'h007C3F80,
    32'h01F1F800, 32'h07C7C1E0, 32'h0F1F0610, 32'h1E7C0000,
    32'h04F00000, 32'h61E40008, 32'h78480010, 32'h4E100018,
    32'h53906070, 32'h5CA09FC8, 32'h7CA10492, 32'h74A10924,
    32'h7FB50248, 32'h77B08010, 32'h7FB44100, 32'h77BB2040,
    32'h7FBC1000, 32'h77BFF800, 32'h7FBFFC00, 32'h3FBFF000,
    32'h1FBFC000, 32'h07BE0000, 32'h01B00000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0003C000,
    32'h000C3000, 32'h00300C00, 32'h00C22300, 32'h070080C0,
    32'h08255030, 32'h100BA808, 32'h2137F504, 32'h304AE80C,
    32'h3C155234, 32'h2B0080EC, 32'h35C22354, 32'h1AB00EAC,
    32'h0D5C1558, 32'h03ABEAE0, 32'h00D55580, 32'h003AAE00,
    32'h000D5800, 32'h0003E000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  localparam logic [31:0] SHAPE_INK [128] = '{
    32'h00300000, 32'h00E80000, 32'h01D80000, 32'h0374F000,
    32'h07EFFE00, 32'h07BC0780, 32'h0FE07FE0, 32'h0F83C070,
    32'h1E0E0708, 32'h183838FF, 32'h30E0F7D4, 32'h6183EEFF,
    32'h7B0FDFA8, 32'h9E1BDDFE, 32'h87B7BF50, 32'hB1EFBBF8,
    32'hAC6F7E00, 32'hA35F6FA0, 32'h835EF868, 32'h8B5EDEC0,
    32'h804AF1C8, 32'h884F6F80, 32'h804B9F08, 32'h8844FC10,
    32'h8043F020, 32'h884000C0, 32'h80400300, 32'h40400C00,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0030F000,
    32'h00F7FE00, 32'h01BC0780, 32'h03E07FE0, 32'h0783C070,
    32'h0E0E07F8, 32'h18383E18, 32'h30E0F9E8, 32'h6183FFF8,
    32'h7B0FF808, 32'h9E1BE7F0, 32'h87B7DF7F, 32'hB1EFBFD4,
    32'hAC6F7EFF, 32'hA35F7FA6, 32'h835EFDF8, 32'h8B5ED740,
    32'h804AF008, 32'h884F6F80, 32'h804B9F08, 32'h8844FC10,
    32'h8043F020, 32'h884000C0, 32'h80400300, 32'h40400C00,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h0000F000,
    32'h0007FE00, 32'h003C0780, 32'h00E07FE0, 32'h0383C070,
    32'h0E0E07F8, 32'h18383E18, 32'h30E0F9E8, 32'h6183FFF8,
    32'h7B0FFFF8, 32'h9E1BFFF0, 32'h87B7FFE8, 32'hB1EFFFE0,
    32'hAC6F9F88, 32'hA35F6036, 32'h835EFB6D, 32'h8B5EF6DB,
    32'h804AFDB6, 32'h884F7FEE, 32'h804BBEFC, 32'h8844DFBC,
    32'h8043EFF8, 32'h884007F0, 32'h804003E0, 32'h40400CC0,
    32'h20403000, 32'h1841C000, 32'h064E0000, 32'h01F00000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h0003C000, 32'h000FF000, 32'h003DDC00, 32'h00FF7F00,
    32'h07DAAFC0, 32'h0FF457F0, 32'h1EC80AF8, 32'h0FB517F0,
    32'h03EAADC8, 32'h14FF7F10, 32'h0A3DDCA8, 32'h054FF150,
    32'h02A3EAA0, 32'h00541500, 32'h002AAA00, 32'h00055000,
    32'h0002A000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef struct {
    logic              action;
    logic [2:0]        slot;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [2:0]        image;
    logic [6:0]        line;
  } sprite_cmd_t;

  typedef struct {
    logic [6:0]  line;
    logic [63:0] left;
    logic [63:0] right;
  } scanline_t;

  class line_scoreboard;
    int        slot_x   [NUM_SLOTS];
    int        slot_y   [NUM_SLOTS];
    int        slot_img [NUM_SLOTS];
    scanline_t due_lines[$];
    int        mismatches;

    function new();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_x[s]   = 0;
        slot_y[s]   = -32;
        slot_img[s] = 0;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return due_lines.size();
    endfunction

    // Pose 1 serves images 1 and 3; codes past the toast have no shape.
    function int shape_of(int img);
      case (img)
        0:       return 0;
        1, 3:    return 1;
        2:       return 2;
        4:       return 3;
        default: return -1;
      endcase
    endfunction

    // Bit 127 is column 0.
    function logic [127:0] compose(int line);
      logic [127:0] px;
      logic [31:0]  m;
      logic [31:0]  b;
      int           row;
      int           shp;
      int           sx;
      px = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        row = line - slot_y[s];
        shp = shape_of(slot_img[s]);
        if (row < 0 || row >= SPR_EDGE || row >= 32 || shp < 0) continue;
        m = SHAPE_MASK[shp * 32 + row];
        b = SHAPE_INK[shp * 32 + row];
        for (int c = 0; c < SPR_EDGE && c < 32; c++) begin
          sx = slot_x[s] + c;
          if (sx < 0 || sx >= SCREEN_W || sx >= 128) continue;
          if (m[31 - c]) px[127 - sx] = 1'b0;
          if (b[31 - c]) px[127 - sx] = 1'b1;
        end
      end
      return px;
    endfunction

    function void note_input(sprite_cmd_t c);
      logic [127:0] px;
      scanline_t    e;
      if (c.action == msc_pkg::ACT_WRITE) begin
        if (int'(c.slot) < NUM_SLOTS) begin
          slot_x[c.slot]   = int'(c.x);
          slot_y[c.slot]   = int'(c.y);
          slot_img[c.slot] = int'(c.image);
        end
      end else begin
        px      = compose(int'(c.line));
        e.line  = c.line;
        e.left  = px[127:64];
        e.right = px[63:0];
        due_lines.push_back(e);
      end
    endfunction

    function void check_line(logic [6:0] line, logic [63:0] left, logic [63:0] right);
      scanline_t e;
      if (due_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected line %0d left %h right %h", $realtime, line, left, right);
        return;
      end
      e = due_lines.pop_front();
      if (line !== e.line || left !== e.left || right !== e.right) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: line mismatch", $realtime);
          if (line !== e.line)
            $display("  line_index   exp %0d got %0d", e.line, line);
          if (left !== e.left)
            $display("  pixels_left  exp %h got %h", e.left, left);
          if (right !== e.right)
            $display("  pixels_right exp %h got %h", e.right, right);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic hold_off_req;
  logic burst;
  int   idle_cycles;

  msc_in_if  cmd_bus ();
  msc_out_if line_bus ();

  line_scoreboard sb = new();

  masked_sprite_line_compositor #(
    .NUM_SPRITES(NUM_SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_bus),
    .out_o (line_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short, a few long.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sprite_cmd_t mk_write(int slot, int x, int y, int img);
    sprite_cmd_t c;
    c.action = msc_pkg::ACT_WRITE;
    c.slot   = 3'(slot);
    c.x      = 9'(x);
    c.y      = 9'(y);
    c.image  = 3'(img);
    c.line   = 7'($urandom_range(0, 127));
    return c;
  endfunction

  function automatic sprite_cmd_t mk_render(int line);
    sprite_cmd_t c;
    c.action = msc_pkg::ACT_RENDER;
    c.slot   = 3'($urandom_range(0, 7));
    c.x      = 9'($urandom_range(0, 511));
    c.y      = 9'($urandom_range(0, 511));
    c.image  = 3'($urandom_range(0, 7));
    c.line   = 7'(line);
    return c;
  endfunction

  // Half renders of a random line; writes mostly place sprites that land on screen, the rest between -64 and 191.
  function automatic sprite_cmd_t random_cmd();
    int slot;
    int x;
    int y;
    int img;
    if ($urandom_range(0, 1)) return mk_render($urandom_range(0, 127));
    slot = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    if ($urandom_range(0, 3) != 0) begin
      x = $urandom_range(0, 158) - 31;
      y = $urandom_range(0, 158) - 31;
    end else begin
      x = $urandom_range(0, 255) - 64;
      y = $urandom_range(0, 255) - 64;
    end
    img = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    return mk_write(slot, x, y, img);
  endfunction

  task automatic send_cmd(input sprite_cmd_t c);
    cmd_bus.valid        <= 1'b1;
    cmd_bus.action       <= c.action;
    cmd_bus.sprite_slot  <= c.slot;
    cmd_bus.sprite_x     <= c.x;
    cmd_bus.sprite_y     <= c.y;
    cmd_bus.sprite_image <= c.image;
    cmd_bus.line_y       <= c.line;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    sprite_cmd_t directed[$];
    sprite_cmd_t c;
    int          counted;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.action       <= msc_pkg::ACT_WRITE;
    cmd_bus.sprite_slot  <= '0;
    cmd_bus.sprite_x     <= '0;
    cmd_bus.sprite_y     <= '0;
    cmd_bus.sprite_image <= '0;
    cmd_bus.line_y       <= '0;
    hold_off_req = 1'b0;
    burst        = 1'b0;
    counted      = 0;

    directed.push_back(mk_render(0));                 // table straight out of reset
    directed.push_back(mk_write(0, 0, 0, 0));
    directed.push_back(mk_render(0));
    directed.push_back(mk_render(31));                // bottom row of the sprite
    directed.push_back(mk_write(1, 10, 5, 1));        // overlaps slot 0 from above
    directed.push_back(mk_render(12));
    directed.push_back(mk_render(36));
    directed.push_back(mk_write(4, -31, 100, 4));     // clipped at the left edge
    directed.push_back(mk_write(3, 120, 96, 2));      // clipped at the right edge
    directed.push_back(mk_render(110));
    directed.push_back(mk_write(2, 48, 90, 3));       // straddles the two pixel words
    directed.push_back(mk_render(105));
    directed.push_back(mk_write(5, 0, 0, 0));         // slot out of range
    directed.push_back(mk_write(7, -1, -1, 7));
    directed.push_back(mk_render(100));
    directed.push_back(mk_write(0, -64, -64, 5));     // shapeless image, lowest position
    directed.push_back(mk_write(1, 191, 191, 6));
    directed.push_back(mk_write(2, 117, 127, 0));     // one lit pixel in the last column
    directed.push_back(mk_write(3, -64, 127, 7));
    directed.push_back(mk_render(127));
    directed.push_back(mk_render(96));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_cmd(directed[i]);
      pause_sender(sender_gap());
    end

    while (counted < RANDOM_ITEMS) begin
      if (counted % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (counted == 400) hold_off_req = 1'b1;
      c = random_cmd();
      send_cmd(c);
      if (!(c.action == msc_pkg::ACT_WRITE && int'(c.slot) >= NUM_SLOTS)) counted++;
      pause_sender(sender_gap());
    end
    cmd_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Line receiver: random stalls, occasional free-running stretches, one long hold-off.
  initial begin : receiver
    int   stall_left;
    int   free_left;
    int   r;
    logic held;
    stall_left = 0;
    free_left  = 0;
    held       = 1'b0;
    line_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        line_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        line_bus.ready <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        line_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        line_bus.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          free_left = $urandom_range(30, 150);
          line_bus.ready <= 1'b1;
        end else if (r < 65) begin
          line_bus.ready <= 1'b1;
        end else begin
          stall_left = stall_len() - 1;
          line_bus.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : take_cmd
    sprite_cmd_t seen;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      seen.action = cmd_bus.action;
      seen.slot   = cmd_bus.sprite_slot;
      seen.x      = cmd_bus.sprite_x;
      seen.y      = cmd_bus.sprite_y;
      seen.image  = cmd_bus.sprite_image;
      seen.line   = cmd_bus.line_y;
      sb.note_input(seen);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && line_bus.valid && line_bus.ready)
      sb.check_line(line_bus.line_index, line_bus.pixels_left, line_bus.pixels_right);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_bus.valid && cmd_bus.ready) || (line_bus.valid && line_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
